>>> rtl/core/srsag_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// sine row-shift address generator. No dependencies.
package srsag_pkg;

  // fixed field widths
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned INDEX_W     = 24;
  localparam int unsigned LOG2_W      = 4;
  localparam int unsigned Q15_W       = 16;
  localparam int unsigned SINE_MAG_W  = 15;
  localparam int unsigned PROD_W      = 29;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // parameter defaults
  localparam int unsigned MAX_SIZE_LOG2_DEF      = 12;
  localparam int unsigned SINE_QUARTER_DEPTH_DEF = 256;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // half pi in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // register reset values
  localparam logic [LOG2_W-1:0] WIDTH_LOG2_RST  = 4'd8;
  localparam logic [LOG2_W-1:0] HEIGHT_LOG2_RST = 4'd8;
  localparam logic [Q15_W-1:0]  AMPLITUDE_RST   = 16'd0;
  localparam logic [Q15_W-1:0]  PERIOD_RST      = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_LOG2  = 3'd0,
    REG_HEIGHT_LOG2 = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_PERIOD      = 3'd3,
    REG_TILE_U      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LOG2_W-1:0] width_log2;
    logic [LOG2_W-1:0] height_log2;
    logic [Q15_W-1:0]  amplitude;
    logic [Q15_W-1:0]  period;
    logic              tile_u;
  } cfg_t;

  // item handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [PROD_W-1:0]  phase_prod;
  } front_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // one quarter-wave entry, Q1.15, from a Taylor series in Q30
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned i,
                                                      input int unsigned depth_log2);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (HALF_PI_Q30 * 64'(i)) >> depth_log2;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return SINE_MAG_W'(r);
  endfunction

endpackage

>>> rtl/core/srsag_in_if.sv
// Destination coordinate channel.
// Depends on srsag_pkg.
interface srsag_in_if;
  import srsag_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;

  modport source (output valid, output dest_x, output dest_y, input ready);
  modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

>>> rtl/core/srsag_out_if.sv
// Source address channel.
// Depends on srsag_pkg.
interface srsag_out_if;
  import srsag_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic [INDEX_W-1:0] src_index;

  modport source (output valid, output src_x, output src_y, output src_index, input ready);
  modport sink   (input valid, input src_x, input src_y, input src_index, output ready);
endinterface

>>> rtl/core/srsag_cfg_if.sv
// Register write channel.
// Depends on srsag_pkg.
interface srsag_cfg_if;
  import srsag_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

>>> rtl/core/srsag_fifo.sv
// Short queue between the front and back parts.
// Depends on srsag_pkg.
module srsag_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  srsag_pkg::front_item_t item_i,
  input  logic                  pop_i,
  output srsag_pkg::front_item_t item_o,
  output srsag_pkg::q_status_t  status_o
);
  import srsag_pkg::*;

  front_item_t        mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign status_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/srsag_front.sv
// Front part: accepts destination coordinates and forms the phase product
// period times row. Depends on srsag_pkg and srsag_in_if.
module srsag_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srsag_pkg::cfg_t        cfg_i,
  srsag_in_if.sink               in_i,
  input  srsag_pkg::q_status_t   q_status_i,
  output logic                   push_o,
  output srsag_pkg::front_item_t item_o
);
  import srsag_pkg::*;

  logic                      valid_q;
  logic                      advance;
  logic signed [PROD_W-1:0]  prod_d;
  front_item_t               item_q;

  // stage frees up when empty or when its item moves into the queue
  assign advance    = !valid_q || !q_status_i.full;
  assign in_i.ready = advance;
  assign push_o     = valid_q && !q_status_i.full;
  assign item_o     = item_q;

  // signed period times unsigned row
  assign prod_d = PROD_W'($signed(cfg_i.period)) * $signed(PROD_W'(in_i.dest_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      item_q.dest_x     <= in_i.dest_x;
      item_q.dest_y     <= in_i.dest_y;
      item_q.phase_prod <= prod_d;
    end
  end

endmodule

>>> rtl/core/srsag_back.sv
// Back part: phase index, sine lookup, shift, rounding, wrap or clamp and the
// linear index, as a five-stage pipeline. Depends on srsag_pkg and srsag_out_if.
module srsag_back #(
  parameter int unsigned MAX_SIZE_LOG2      = srsag_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned SINE_QUARTER_DEPTH = srsag_pkg::SINE_QUARTER_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srsag_pkg::cfg_t        cfg_i,
  input  srsag_pkg::front_item_t item_i,
  input  srsag_pkg::q_status_t   q_status_i,
  output logic                   pop_o,
  srsag_out_if.source            out_o
);
  import srsag_pkg::*;

  localparam int unsigned DL    = $clog2(SINE_QUARTER_DEPTH);
  localparam int unsigned IDX_W = DL + 2;
  localparam int unsigned PH_W  = 10 + MAX_SIZE_LOG2 + DL;
  localparam int unsigned EW    = MAX_SIZE_LOG2 + 32;
  localparam int unsigned Q_W   = MAX_SIZE_LOG2 + 2;
  localparam int unsigned IX_W  = ((MAX_SIZE_LOG2 > COORD_W) ? MAX_SIZE_LOG2 : COORD_W) + 2;
  localparam int unsigned SX_W  = MAX_SIZE_LOG2;
  localparam int unsigned ADR_W = DL + 1;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;

  // quarter-wave table, built at elaboration
  logic [SINE_MAG_W-1:0] sine_rom [SINE_QUARTER_DEPTH+1];
  for (genvar g = 0; g <= SINE_QUARTER_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, DL);
  end

  // whole pipeline moves when the output register can take a request
  assign en          = !out_v_q || out_o.ready;
  assign pop_o       = en && !q_status_i.empty;
  assign out_o.valid = out_v_q;

  // stage 1: phase index, rounded half up, wrapped over the full wave
  logic signed [PH_W-1:0] ph_ext;
  logic [PH_W-1:0]        ph_sum;
  logic [PH_W-1:0]        ph_shr;
  logic [IDX_W-1:0]       idx_q;
  logic [COORD_W-1:0]     dx1_q, dy1_q;

  always_comb begin
    ph_ext = PH_W'($signed(item_i.phase_prod));
    ph_sum = (PH_W'(ph_ext) << (2 + DL))
           + (PH_W'(1) << (5'd7 + 5'(cfg_i.height_log2)));
    ph_shr = ph_sum >> (5'd8 + 5'(cfg_i.height_log2));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= ph_shr[IDX_W-1:0];
      dx1_q <= item_i.dest_x;
      dy1_q <= item_i.dest_y;
    end
  end

  // stage 2: table read with quadrant folding
  logic [1:0]            quad;
  logic [DL-1:0]         rem;
  logic [ADR_W-1:0]      rom_addr;
  logic [SINE_MAG_W-1:0] mag_q;
  logic                  neg_q;
  logic [COORD_W-1:0]    dx2_q, dy2_q;

  always_comb begin
    quad     = idx_q[IDX_W-1:DL];
    rem      = idx_q[DL-1:0];
    rom_addr = quad[0] ? (ADR_W'(SINE_QUARTER_DEPTH) - ADR_W'(rem)) : ADR_W'(rem);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= sine_rom[rom_addr];
      neg_q <= quad[1];
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
    end
  end

  // stage 3: amplitude times signed sine, Q2.30
  logic signed [SINE_MAG_W+1:0] sine_s;
  logic signed [31:0]           amp_x, sine_x, mult_d;
  logic signed [31:0]           mult_q;
  logic [COORD_W-1:0]           dx3_q, dy3_q;

  always_comb begin
    sine_s = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
    amp_x  = 32'($signed(cfg_i.amplitude));
    sine_x = 32'(sine_s);
    mult_d = amp_x * sine_x;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mult_q <= mult_d;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
    end
  end

  // stage 4: scale by width, round half up, floor, add column
  logic signed [EW-1:0]   shift_sum;
  logic signed [Q_W-1:0]  delta;
  logic signed [IX_W-1:0] ix_d, ix_q;
  logic [COORD_W-1:0]     dy4_q;

  always_comb begin
    shift_sum = (EW'(mult_q) <<< cfg_i.width_log2) + (EW'(1) << 29);
    delta     = shift_sum[EW-1:30];
    ix_d      = IX_W'(delta) + $signed(IX_W'(dx3_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ix_q  <= ix_d;
      dy4_q <= dy3_q;
    end
  end

  // stage 5: wrap or clamp, then linear index
  logic [SX_W-1:0]    wmask;
  logic [SX_W-1:0]    sx;
  logic [COORD_W-1:0] src_x_q, src_y_q;
  logic [INDEX_W-1:0] src_index_q;

  always_comb begin
    wmask = SX_W'(((SX_W + 1)'(1) << cfg_i.width_log2) - (SX_W + 1)'(1));
    if (cfg_i.tile_u) begin
      sx = ix_q[SX_W-1:0] & wmask;
    end else if (ix_q < 0) begin
      sx = '0;
    end else if (ix_q > $signed(IX_W'(wmask))) begin
      sx = wmask;
    end else begin
      sx = ix_q[SX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_x_q     <= COORD_W'(sx);
      src_y_q     <= dy4_q;
      src_index_q <= INDEX_W'(sx) + (INDEX_W'(dy4_q) << cfg_i.width_log2);
    end
  end

  assign out_o.src_x     = src_x_q;
  assign out_o.src_y     = src_y_q;
  assign out_o.src_index = src_index_q;

  // valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= !q_status_i.empty;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

endmodule

>>> rtl/core/sine_row_shift_address_gen.sv
// Top level of the sine row-shift address generator: register file, front,
// queue and back. Depends on srsag_pkg, the channel interfaces and all submodules.
//
// Maps one destination pixel per clock to its source pixel: each row is shifted
// sideways by amplitude * width * sin(2*pi*period*row/height), rounded half up,
// then wrapped (tile_u = 1) or clamped (tile_u = 0) to the row. Sustained rate
// is one request per cycle while the output takes each result; requests pass
// the front register, the queue and the five back stages (phase index, sine
// table read, amplitude multiply, scale and round, wrap or clamp). The front
// keeps taking requests while the output is stalled until the four-entry queue
// fills. The sine comes from a quarter-wave table of SINE_QUARTER_DEPTH+1 Q1.15
// entries read once per cycle. Widths and heights above 2^MAX_SIZE_LOG2 saturate
// to that size. Registers must be written while idle; the block does not check.
module sine_row_shift_address_gen #(
  parameter int unsigned MAX_SIZE_LOG2      = srsag_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned SINE_QUARTER_DEPTH = srsag_pkg::SINE_QUARTER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srsag_cfg_if.sink   cfg_i,
  srsag_in_if.sink    in_i,
  srsag_out_if.source out_o
);
  import srsag_pkg::*;

  cfg_t        cfg_q;
  cfg_t        cfg_eff;
  logic        push;
  logic        pop;
  front_item_t front_item;
  front_item_t q_item;
  q_status_t   q_status;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_log2  <= WIDTH_LOG2_RST;
      cfg_q.height_log2 <= HEIGHT_LOG2_RST;
      cfg_q.amplitude   <= AMPLITUDE_RST;
      cfg_q.period      <= PERIOD_RST;
      cfg_q.tile_u      <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        REG_WIDTH_LOG2:  cfg_q.width_log2  <= cfg_i.wdata[LOG2_W-1:0];
        REG_HEIGHT_LOG2: cfg_q.height_log2 <= cfg_i.wdata[LOG2_W-1:0];
        REG_AMPLITUDE:   cfg_q.amplitude   <= cfg_i.wdata[Q15_W-1:0];
        REG_PERIOD:      cfg_q.period      <= cfg_i.wdata[Q15_W-1:0];
        REG_TILE_U:      cfg_q.tile_u      <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // saturate oversized image sizes
  always_comb begin
    cfg_eff = cfg_q;
    if (32'(cfg_q.width_log2) > MAX_SIZE_LOG2) begin
      cfg_eff.width_log2 = LOG2_W'(MAX_SIZE_LOG2);
    end
    if (32'(cfg_q.height_log2) > MAX_SIZE_LOG2) begin
      cfg_eff.height_log2 = LOG2_W'(MAX_SIZE_LOG2);
    end
  end

  srsag_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_eff),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (front_item)
  );

  srsag_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  srsag_back #(
    .MAX_SIZE_LOG2      (MAX_SIZE_LOG2),
    .SINE_QUARTER_DEPTH (SINE_QUARTER_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_eff),
    .item_i     (q_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // queue never written when full nor read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_status.full))
    else $error("queue push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_status.empty))
    else $error("queue pop while empty");

  // source column always lies inside the configured row width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.src_x >> cfg_eff.width_log2) == '0))
    else $error("source column outside row");

endmodule

>>> tb/srsag_addr_checker.sv
`timescale 1ns / 1ps
// Checker for the sine row-shift address generator: mirrors the register
// writes, predicts each source address and compares it with the result.
// Depends on srsag_pkg and the three channel interfaces.
module srsag_addr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  srsag_cfg_if        cfg_i,
  srsag_in_if         in_i,
  srsag_out_if        out_i,
  output int unsigned results_o,
  output int unsigned failures_o
);
  import srsag_pkg::*;

  localparam int unsigned SIZE_LOG2_MAX = MAX_SIZE_LOG2_DEF;
  localparam int unsigned QDEPTH        = SINE_QUARTER_DEPTH_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [INDEX_W-1:0] src_index;
  } src_addr_t;

  // quarter-wave sine, Q1.15
  logic [SINE_MAG_W-1:0] quarter_sine [0:QDEPTH];

  // register mirror
  logic [LOG2_W-1:0] width_log2_q;
  logic [LOG2_W-1:0] height_log2_q;
  logic [Q15_W-1:0]  amplitude_q;
  logic [Q15_W-1:0]  period_q;
  logic              tile_u_q;

  src_addr_t   expected_addrs [$];
  int unsigned fail_cnt;

  // taylor series of sin in Q30, rounded to Q15
  function automatic logic [SINE_MAG_W-1:0] sine_q15(input int unsigned step);
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        term;
    logic [63:0]        rounded;
    logic signed [63:0] acc;
    ang    = (HALF_PI_Q30 * 64'(step)) / 64'(QDEPTH);
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = $signed(ang);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    rounded = ($unsigned(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32767) rounded = 64'd32767;
    return SINE_MAG_W'(rounded);
  endfunction

  initial begin
    for (int i = 0; i <= QDEPTH; i++) quarter_sine[i] = sine_q15(i);
  end

  // source address of one destination pixel under the mirrored registers
  function automatic src_addr_t map_coord(input logic [COORD_W-1:0] dx,
                                          input logic [COORD_W-1:0] dy);
    int unsigned        wl;
    int unsigned        hl;
    logic [COORD_W-1:0] wmask;
    logic signed [63:0] per_s;
    logic signed [63:0] amp_s;
    logic signed [63:0] dx_s;
    logic signed [63:0] dy_s;
    logic signed [63:0] mag_s;
    logic signed [63:0] sine;
    logic signed [63:0] shifted;
    logic signed [63:0] col;
    logic [63:0]        phase;
    logic [9:0]         step;
    logic [COORD_W-1:0] sx;
    src_addr_t          addr;
    wl    = (width_log2_q > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : width_log2_q;
    hl    = (height_log2_q > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : height_log2_q;
    wmask = COORD_W'((1 << wl) - 1);
    per_s = $signed(period_q);
    amp_s = $signed(amplitude_q);
    dx_s  = {52'd0, dx};
    dy_s  = {52'd0, dy};

    // phase over four quadrants, rounded half up
    phase = per_s * dy_s;
    phase = phase * 64'(4 * QDEPTH) + (64'd1 << (7 + hl));
    step  = 10'(phase >> (8 + hl));

    // full wave from the quarter table
    if (step[8]) begin
      mag_s = {49'd0, quarter_sine[QDEPTH - int'(step[7:0])]};
    end else begin
      mag_s = {49'd0, quarter_sine[step[7:0]]};
    end
    sine = step[9] ? -mag_s : mag_s;

    // shifted column, floored after adding one half
    shifted = (dx_s <<< 30) + amp_s * sine * (64'sd1 <<< wl) + (64'sd1 <<< 29);
    col     = shifted >>> 30;

    // wrap or clamp to the row
    if (tile_u_q) begin
      sx = COORD_W'(col) & wmask;
    end else if (col < 0) begin
      sx = '0;
    end else if (col > $signed({52'd0, wmask})) begin
      sx = wmask;
    end else begin
      sx = COORD_W'(col);
    end

    addr.src_x     = sx;
    addr.src_y     = dy;
    addr.src_index = INDEX_W'({12'd0, sx} + ({12'd0, dy} << wl));
    return addr;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    src_addr_t head;
    if (!rst_ni) begin
      width_log2_q  = WIDTH_LOG2_RST;
      height_log2_q = HEIGHT_LOG2_RST;
      amplitude_q   = AMPLITUDE_RST;
      period_q      = PERIOD_RST;
      tile_u_q      = 1'b0;
      expected_addrs.delete();
      fail_cnt      = 0;
      results_o     <= 0;
      failures_o    <= 0;
    end else begin
      // compare a result against the oldest request
      if (out_i.valid && out_i.ready) begin
        results_o <= results_o + 1;
        if (expected_addrs.size() == 0) begin
          $error("result with no request pending: src_x %0d src_y %0d src_index %0d",
                 out_i.src_x, out_i.src_y, out_i.src_index);
          fail_cnt++;
        end else begin
          head = expected_addrs.pop_front();
          if (out_i.src_x !== head.src_x) begin
            $error("src_x mismatch: expected %0d, actual %0d", head.src_x, out_i.src_x);
            fail_cnt++;
          end
          if (out_i.src_y !== head.src_y) begin
            $error("src_y mismatch: expected %0d, actual %0d", head.src_y, out_i.src_y);
            fail_cnt++;
          end
          if (out_i.src_index !== head.src_index) begin
            $error("src_index mismatch: expected %0d, actual %0d",
                   head.src_index, out_i.src_index);
            fail_cnt++;
          end
        end
      end

      // predict an accepted request, appended at the tail
      if (in_i.valid && in_i.ready) begin
        expected_addrs.insert(expected_addrs.size(), map_coord(in_i.dest_x, in_i.dest_y));
      end

      // register write
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.reg_idx)
          REG_WIDTH_LOG2:  width_log2_q  = cfg_i.wdata[LOG2_W-1:0];
          REG_HEIGHT_LOG2: height_log2_q = cfg_i.wdata[LOG2_W-1:0];
          REG_AMPLITUDE:   amplitude_q   = cfg_i.wdata;
          REG_PERIOD:      period_q      = cfg_i.wdata;
          REG_TILE_U:      tile_u_q      = cfg_i.wdata[0];
          default: ;
        endcase
      end
      failures_o <= fail_cnt;
    end
  end

endmodule

>>> tb/sine_row_shift_address_gen_test.sv
`timescale 1ns / 1ps
// Top of the sine row-shift address generator testbench: clock, reset,
// register and coordinate stimulus, output stalls, watchdog and verdict.
// Depends on srsag_pkg, the channel interfaces, the block and srsag_addr_checker.
module sine_row_shift_address_gen_test;
  import srsag_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_ITEMS = 100;

  logic clk_i = 1'b0;
  logic rst_ni;

  srsag_cfg_if cfg_bus ();
  srsag_in_if  coord_bus ();
  srsag_out_if addr_bus ();

  int unsigned results_seen;
  int unsigned failures;
  int unsigned items_sent;
  int unsigned reg_writes;
  int unsigned settings_used;
  int unsigned cur_wl;
  int unsigned cur_hl;
  bit          idle_on;

  sine_row_shift_address_gen DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (coord_bus),
    .out_o  (addr_bus)
  );

  srsag_addr_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_bus),
    .in_i       (coord_bus),
    .out_i      (addr_bus),
    .results_o  (results_seen),
    .failures_o (failures)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one register write, valid stays high for the next one
  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.reg_idx <= r;
    cfg_bus.wdata   <= d;
    do @(posedge clk_i); while (!cfg_bus.ready);
    reg_writes++;
  endtask

  // full register setting, written while the block is idle
  task automatic program_regs(input logic [LOG2_W-1:0] w, input logic [LOG2_W-1:0] h,
                              input logic [Q15_W-1:0] amp, input logic [Q15_W-1:0] per,
                              input logic tile);
    write_reg(REG_WIDTH_LOG2, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT_LOG2, CFG_DATA_W'(h));
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_PERIOD, per);
    write_reg(REG_TILE_U, CFG_DATA_W'(tile));
    cfg_bus.valid <= 1'b0;
    cur_wl = (w > MAX_SIZE_LOG2_DEF) ? MAX_SIZE_LOG2_DEF : w;
    cur_hl = (h > MAX_SIZE_LOG2_DEF) ? MAX_SIZE_LOG2_DEF : h;
    settings_used++;
  endtask

  // one coordinate request, with an optional idle burst before it
  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      coord_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coord_bus.valid  <= 1'b1;
    coord_bus.dest_x <= x;
    coord_bus.dest_y <= y;
    do @(posedge clk_i); while (!coord_bus.ready);
    items_sent++;
  endtask

  // stop requesting and wait for every result
  task automatic drain_requests();
    coord_bus.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  // log2 size biased toward the extremes and the oversized range
  function automatic logic [LOG2_W-1:0] pick_log2();
    case ($urandom_range(0, 7))
      0:       return LOG2_W'($urandom_range(13, 15));
      1:       return '0;
      2:       return LOG2_W'(MAX_SIZE_LOG2_DEF);
      default: return LOG2_W'($urandom_range(1, 11));
    endcase
  endfunction

  // output side stalls in random bursts
  initial begin
    int unsigned stall_left;
    stall_left     = 0;
    addr_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        addr_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left     = $urandom_range(1, 4) - 1;
        addr_bus.ready <= 1'b0;
      end else begin
        addr_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((coord_bus.valid && coord_bus.ready) || (addr_bus.valid && addr_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [LOG2_W-1:0]  w;
    logic [LOG2_W-1:0]  h;
    logic [Q15_W-1:0]   amp;
    logic [Q15_W-1:0]   per;
    logic [COORD_W-1:0] xmask;
    logic [COORD_W-1:0] hmask;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    int unsigned        run_len;
    int unsigned        phase_start;

    items_sent    = 0;
    reg_writes    = 0;
    settings_used = 1;
    cur_wl        = WIDTH_LOG2_RST;
    cur_hl        = HEIGHT_LOG2_RST;
    idle_on       = 1'b1;

    rst_ni           <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.reg_idx  <= REG_WIDTH_LOG2;
    cfg_bus.wdata    <= '0;
    coord_bus.valid  <= 1'b0;
    coord_bus.dest_x <= '0;
    coord_bus.dest_y <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: no shift, corners and a column outside the image
    send_coord(12'd0, 12'd0);
    send_coord(12'd255, 12'd255);
    send_coord(12'd256, 12'd7);
    send_coord(12'd4095, 12'd4095);
    drain_requests();

    // oversized sizes, largest positive amplitude and period, wrap
    program_regs(4'd15, 4'd15, 16'h7FFF, 16'h7FFF, 1'b1);
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd0, 12'd1);
    send_coord(12'd4095, 12'd1);
    send_coord(12'd2048, 12'd3000);
    send_coord(12'd100, 12'd4095);
    drain_requests();

    // one-pixel image, most negative amplitude and period, clamp
    program_regs(4'd0, 4'd0, 16'h8000, 16'h8000, 1'b0);
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd0);
    send_coord(12'd0, 12'd1);
    send_coord(12'd4095, 12'd4095);
    drain_requests();

    // quarter-wave points of one cycle, half-width shift, clamp at both edges
    program_regs(4'd12, 4'd4, 16'h4000, 16'h0100, 1'b0);
    send_coord(12'd0, 12'd4);
    send_coord(12'd4095, 12'd4);
    send_coord(12'd0, 12'd12);
    send_coord(12'd4095, 12'd12);
    send_coord(12'd2048, 12'd8);
    drain_requests();

    // oversized height only, negative amplitude, wrap
    program_regs(4'd6, 4'd13, 16'hC000, 16'h0180, 1'b1);
    send_coord(12'd63, 12'd5);
    send_coord(12'd0, 12'd100);
    drain_requests();

    // random settings with raster runs, scattered pixels and noise
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph < PHASES - 3) && (ph % 4 != 3);
      w = pick_log2();
      h = pick_log2();
      case ($urandom_range(0, 5))
        0:       amp = 16'h7FFF;
        1:       amp = 16'h8000;
        2:       amp = 16'($signed($urandom_range(0, 2048)) - 1024);
        default: amp = 16'($urandom);
      endcase
      if ($urandom_range(0, 2) == 0) begin
        per = 16'($urandom);
      end else begin
        per = 16'($signed($urandom_range(0, 2048)) - 1024);
      end
      program_regs(w, h, amp, per, 1'($urandom));
      xmask = COORD_W'((1 << cur_wl) - 1);
      hmask = COORD_W'((1 << cur_hl) - 1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: begin
            send_coord(COORD_W'($urandom), COORD_W'($urandom));
          end
          1, 2, 3, 4: begin
            send_coord(COORD_W'($urandom) & xmask, COORD_W'($urandom) & hmask);
          end
          default: begin
            // part of a scan line
            x0      = COORD_W'($urandom) & xmask;
            y0      = COORD_W'($urandom) & hmask;
            run_len = $urandom_range(1, 16);
            for (int k = 0; k < run_len; k++) begin
              send_coord((x0 + COORD_W'(k)) & xmask, y0);
            end
          end
        endcase
      end
      drain_requests();
    end

    // let any stray result show up
    repeat (20) @(posedge clk_i);

    $display("ran %0d coordinate requests under %0d register settings (%0d register writes)",
             items_sent, settings_used, reg_writes);
    $display("results checked: %0d, field mismatches: %0d", results_seen, failures);
    if (failures == 0 && results_seen == items_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
